[rtl/core/skf_pkg.sv]
// Shared types, constants and microcode encoding for the scalar Kalman filter.
// No dependencies; imported by skf_seq, skf_dp and scalar_kalman_filter_unit.
`default_nettype none

package skf_pkg;

	localparam int MEAS_W = 17;   // signed Q8.8
	localparam int VAR_W  = 20;   // unsigned Q4.16
	localparam int GAIN_W = 17;   // unsigned Q1.16, reaches 1.0
	localparam int X_W    = 18;   // held estimate
	localparam int DEN_W  = VAR_W + 1;
	localparam int DIFF_W = 18;
	localparam int MB_W   = DEN_W;                 // multiplier B operand, signed
	localparam int PROD_W = GAIN_W + 1 + MB_W;     // signed product
	localparam int SUM_W  = PROD_W - 16;
	localparam int CNT_W  = 5;
	localparam int STEP_W = 3;

	localparam logic [VAR_W-1:0]        R_RESET   = 20'd6554;
	localparam logic [VAR_W-1:0]        Q_RESET   = 20'd6554;
	localparam logic [VAR_W-1:0]        P_RESET   = 20'd65536;
	localparam logic [VAR_W-1:0]        VAR_SAT   = 20'hFFFFF;
	localparam logic [GAIN_W-1:0]       GAIN_ONE  = 17'd65536;
	localparam logic [CNT_W-1:0]        DIV_STEPS = 5'd16;
	localparam logic signed [SUM_W-1:0] EST_HI    = 23'sd46080;
	localparam logic signed [SUM_W-1:0] EST_LO    = -23'sd46080;

	// configuration register indexes
	localparam logic CFG_R = 1'b0;
	localparam logic CFG_Q = 1'b1;

	// program steps
	localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] S_DEN   = 3'd1;
	localparam logic [STEP_W-1:0] S_DIVI  = 3'd2;
	localparam logic [STEP_W-1:0] S_DIV   = 3'd3;
	localparam logic [STEP_W-1:0] S_FIX   = 3'd4;
	localparam logic [STEP_W-1:0] S_MUL1  = 3'd5;
	localparam logic [STEP_W-1:0] S_MUL2  = 3'd6;
	localparam logic [STEP_W-1:0] S_WB    = 3'd7;

	typedef enum logic [2:0] {
		OP_LOAD,      // take measurement, predicted variance
		OP_DEN,       // denominator Pp + R
		OP_DIV_INIT,  // top quotient bit, load loop count
		OP_DIV_STEP,  // one restoring divide step
		OP_FIX,       // zero denominator fix, innovation
		OP_MUL1,      // gain * innovation
		OP_MUL2,      // new estimate, (1 - gain) * Pp
		OP_WB         // commit state, fill output register
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_NO_IN,     // wait for an item
		COND_OUT_BUSY,  // wait for output register
		COND_LOOP       // repeat until count runs out
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic exec;
	} ctrl_t;

	typedef struct packed {
		logic busy;
		logic cnt_last;
	} stat_t;

	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
		uword_t w;
		case (pc)
			S_IDLE:  w = '{op: OP_LOAD,     cond: COND_NO_IN,    target: S_IDLE};
			S_DEN:   w = '{op: OP_DEN,      cond: COND_NONE,     target: S_IDLE};
			S_DIVI:  w = '{op: OP_DIV_INIT, cond: COND_NONE,     target: S_IDLE};
			S_DIV:   w = '{op: OP_DIV_STEP, cond: COND_LOOP,     target: S_DIV};
			S_FIX:   w = '{op: OP_FIX,      cond: COND_NONE,     target: S_IDLE};
			S_MUL1:  w = '{op: OP_MUL1,     cond: COND_NONE,     target: S_IDLE};
			S_MUL2:  w = '{op: OP_MUL2,     cond: COND_NONE,     target: S_IDLE};
			S_WB:    w = '{op: OP_WB,       cond: COND_OUT_BUSY, target: S_WB};
			default: w = '{op: OP_LOAD,     cond: COND_NONE,     target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/core/skf_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on skf_pkg.
`default_nettype none

module skf_seq
	import skf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire stat_t stat,
	output ctrl_t      ctrl,
	output logic       in_stall
);

	logic [STEP_W-1:0] pc_q;
	uword_t            uw;
	logic              wait_hit;
	logic              jump;

	assign uw = ucode_rom(pc_q);

	// a step held on a wait condition does nothing
	assign wait_hit = (uw.cond == COND_NO_IN && !in_valid) ||
	                  (uw.cond == COND_OUT_BUSY && stat.busy);
	assign jump     = wait_hit || (uw.cond == COND_LOOP && !stat.cnt_last);

	assign ctrl.op   = uw.op;
	assign ctrl.exec = !wait_hit;
	assign in_stall  = (pc_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (jump) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= STEP_W'(pc_q + 1'b1);
		end
	end

	a_accept_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_IDLE && in_valid) |=> (pc_q == S_DEN))
		else $error("sequencer did not leave idle after an item");

	a_loop_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_DIV && stat.cnt_last) |=> (pc_q == S_FIX))
		else $error("divide loop did not exit on last count");

	a_wb_return: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_WB && !stat.busy) |=> (pc_q == S_IDLE))
		else $error("write-back did not return to idle");

endmodule

`default_nettype wire

[rtl/core/skf_dp.sv]
// Datapath: config and state registers, restoring divider, shared multiplier,
// output register. Driven by skf_seq control; depends on skf_pkg.
`default_nettype none

module skf_dp
	import skf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctrl_t                    ctrl,
	output stat_t                         stat,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [VAR_W-1:0]         cfg_data,
	input  wire logic signed [MEAS_W-1:0] measurement,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [MEAS_W-1:0]      estimate,
	output logic [VAR_W-1:0]              error_variance
);

	logic [VAR_W-1:0]         r_q, q_q, p_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [MEAS_W-1:0] meas_q;
	logic [VAR_W-1:0]         pp_q;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W-1:0]         rem_q;
	logic [GAIN_W-1:0]        quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MEAS_W-1:0] est_nx_q;
	logic signed [MEAS_W-1:0] est_out_q;
	logic [VAR_W-1:0]         var_out_q;
	logic                     out_valid_q;

	logic [DEN_W-1:0]         pq_sum;
	logic [VAR_W-1:0]         pp_sat;
	logic                     ge0;
	logic [DEN_W:0]           rem_sh;
	logic                     ge;
	logic [DEN_W-1:0]         rem_nx;
	logic [GAIN_W-1:0]        mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [SUM_W-1:0]  est_sum;
	logic signed [MEAS_W-1:0] est_clamp;
	logic                     exec_op;

	assign exec_op = ctrl.exec;

	assign pq_sum = {1'b0, p_q} + {1'b0, q_q};
	assign pp_sat = pq_sum[DEN_W-1] ? VAR_SAT : pq_sum[VAR_W-1:0];

	// restoring divide of Pp*2^16 by Pp+R, one quotient bit a step
	assign ge0    = ({1'b0, pp_q} >= den_q);
	assign rem_sh = {rem_q, 1'b0};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign rem_nx = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];

	// shared multiplier: gain * diff, then (1 - gain) * Pp
	always_comb begin
		if (ctrl.op == OP_MUL1) begin
			mul_a = quo_q;
			mul_b = MB_W'(diff_q);
		end else begin
			mul_a = GAIN_W'(GAIN_ONE - quo_q);
			mul_b = $signed({1'b0, pp_q});
		end
	end
	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	// arithmetic shift of the product gives the floor
	assign est_sum = SUM_W'(x_q) + prod_q[PROD_W-1:16];
	always_comb begin
		if (est_sum > EST_HI) begin
			est_clamp = MEAS_W'(EST_HI);
		end else if (est_sum < EST_LO) begin
			est_clamp = MEAS_W'(EST_LO);
		end else begin
			est_clamp = est_sum[MEAS_W-1:0];
		end
	end

	assign stat.busy     = out_valid_q && out_stall;
	assign stat.cnt_last = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= R_RESET;
			q_q <= Q_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_R:   r_q <= cfg_data;
				CFG_Q:   q_q <= cfg_data;
				default: r_q <= r_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			p_q         <= P_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// a new result may land in the same cycle the old one is taken
			if (exec_op && ctrl.op == OP_WB) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (exec_op) begin
				case (ctrl.op)
					OP_DIV_INIT: cnt_q <= DIV_STEPS;
					OP_DIV_STEP: cnt_q <= CNT_W'(cnt_q - 1'b1);
					OP_WB: begin
						x_q <= X_W'(est_nx_q);
						p_q <= prod_q[VAR_W+15:16];
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_op) begin
			case (ctrl.op)
				OP_LOAD: begin
					meas_q <= measurement;
					pp_q   <= pp_sat;
				end
				OP_DEN: den_q <= {1'b0, pp_q} + {1'b0, r_q};
				OP_DIV_INIT: begin
					rem_q <= ge0 ? DEN_W'({1'b0, pp_q} - den_q) : {1'b0, pp_q};
					quo_q <= {{(GAIN_W-1){1'b0}}, ge0};
				end
				OP_DIV_STEP: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[GAIN_W-2:0], ge};
				end
				OP_FIX: begin
					if (den_q == '0) begin
						quo_q <= '0;
					end
					diff_q <= DIFF_W'(meas_q) - x_q;
				end
				OP_MUL1: prod_q <= mul_p;
				OP_MUL2: begin
					est_nx_q <= est_clamp;
					prod_q   <= mul_p;
				end
				OP_WB: begin
					est_out_q <= est_nx_q;
					var_out_q <= prod_q[VAR_W+15:16];
				end
				default: meas_q <= meas_q;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign estimate       = est_out_q;
	assign error_variance = var_out_q;

	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(x_q) <= EST_HI) && (SUM_W'(x_q) >= EST_LO))
		else $error("held estimate out of range");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_op && ctrl.op == OP_MUL1) |-> (quo_q <= GAIN_ONE))
		else $error("gain above one");

	a_wb_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_op && ctrl.op == OP_WB) |=> out_valid_q)
		else $error("write-back did not fill output register");

endmodule

`default_nettype wire

[rtl/core/scalar_kalman_filter_unit.sv]
// Scalar Kalman filter top level. An item is accepted only while the sequencer is idle;
// it then passes the denominator, divide, fix, multiply and write-back steps before the next.
// The divide is the 16-step loop of the shared restoring divider (gain = Pp/(Pp+R)).
// A held output register lets the next item be accepted before the result is taken.
// Reset (arst_n, async, active low): estimate 0, variance 1.0, R and Q 0.1, output empty.
// Depends on skf_pkg, skf_seq and skf_dp.
`default_nettype none

module scalar_kalman_filter_unit
	import skf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [VAR_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [MEAS_W-1:0] measurement,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [MEAS_W-1:0]      estimate,
	output logic [VAR_W-1:0]              error_variance
);

	ctrl_t ctrl;
	stat_t stat;

	skf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_stall (in_stall)
	);

	skf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measurement    (measurement),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.estimate       (estimate),
		.error_variance (error_variance)
	);

endmodule

`default_nettype wire
